// ===== rtl/core/sec_pkg.sv =====
// shared types and constants for the spring energy and constraint block
package sec_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [31:0] STEP_RESET = 32'h0001_0000;
    localparam int SQRT_BITS = 33;
    localparam int DIV_BITS = 95;
    localparam logic KIND_ENERGY = 1'b0;
    localparam logic KIND_CONSTRAINT = 1'b1;

    // spring as it leaves the front end: coordinate differences as magnitudes
    typedef struct packed {
        logic        kind;
        logic [31:0] dmx;
        logic [31:0] dmy;
        logic [31:0] dmz;
        logic [30:0] rest;
        logic [31:0] k;
        logic        lneg;
        logic [31:0] lmag;
    } spring_t;

    // one stage of the shared square root and divide pipeline
    typedef struct packed {
        logic        kind;
        logic [30:0] rest;
        logic [31:0] k;
        logic        lneg;
        logic [31:0] lmag;
        logic        kdz;
        logic [63:0] kd;
        logic [65:0] srem;
        logic [32:0] root;
        logic [94:0] dnum;
        logic [63:0] drem;
        logic [94:0] quo;
    } loop_t;

endpackage

// ===== rtl/core/spring_energy_and_constraint.sv =====
// top level of the spring energy and constraint block
//
// One spring enters per transfer on the s_ channel: two endpoints, rest length,
// stiffness, lagrange multiplier and a kind bit (energy or constraint value).
// One result leaves per spring on the m_ channel, in order: a Q31.32 value and
// a flag that is set when the value was clipped.
// cfg_wr_en writes step_squared from cfg_wr_data; write it only
// while no spring is in flight.
// Throughput is one spring per cycle while the receiver takes results. Each
// result passes through the shared pipeline that produces one quotient bit
// of lambda^2/(2*k*dt^2) per stage (95 stages, the 33 root bits ride in
// the leading stages).
// The front end pushes into a four-entry queue; the back end pipeline moves
// only when its output register is empty or being taken, so a stalled
// receiver freezes the pipeline, the queue fills, and s_ready then drops.
// Reset clears all valid flags and the queue, and sets step_squared to 1.0.
module spring_energy_and_constraint #(
    parameter int QueueDepth = sec_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_first_x,
    input  logic [31:0] s_first_y,
    input  logic [31:0] s_first_z,
    input  logic [31:0] s_second_x,
    input  logic [31:0] s_second_y,
    input  logic [31:0] s_second_z,
    input  logic [30:0] s_rest_len,
    input  logic [31:0] s_spring_k,
    input  logic [31:0] s_multiplier,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_saturated
);

    logic [31:0]      step_sq_reg;
    logic             q_full, q_push, q_pop, q_head_valid;
    sec_pkg::spring_t q_in, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_sq_reg <= sec_pkg::STEP_RESET;
        end else if (cfg_wr_en) begin
            step_sq_reg <= cfg_wr_data;
        end
    end

    sec_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_first_x    (s_first_x),
        .s_first_y    (s_first_y),
        .s_first_z    (s_first_z),
        .s_second_x   (s_second_x),
        .s_second_y   (s_second_y),
        .s_second_z   (s_second_z),
        .s_rest_len   (s_rest_len),
        .s_spring_k   (s_spring_k),
        .s_multiplier (s_multiplier),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    sec_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head)
    );

    logic back_ready;
    assign q_pop = back_ready && q_head_valid;

    sec_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_squared (step_sq_reg),
        .in_valid     (q_head_valid),
        .in_ready     (back_ready),
        .in_data      (q_head),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_saturated  (m_saturated)
    );

endmodule

// ===== rtl/core/sec_front.sv =====
// front end: takes a spring transfer, forms difference magnitudes, pushes to the queue
module sec_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_kind,
    input  logic [31:0]      s_first_x,
    input  logic [31:0]      s_first_y,
    input  logic [31:0]      s_first_z,
    input  logic [31:0]      s_second_x,
    input  logic [31:0]      s_second_y,
    input  logic [31:0]      s_second_z,
    input  logic [30:0]      s_rest_len,
    input  logic [31:0]      s_spring_k,
    input  logic [31:0]      s_multiplier,
    input  logic             q_full,
    output logic             q_push,
    output sec_pkg::spring_t q_data
);

    logic [32:0] dx, dy, dz;
    logic [32:0] ax, ay, az;

    always_comb begin
        dx = {s_first_x[31], s_first_x} - {s_second_x[31], s_second_x};
        dy = {s_first_y[31], s_first_y} - {s_second_y[31], s_second_y};
        dz = {s_first_z[31], s_first_z} - {s_second_z[31], s_second_z};
        ax = dx[32] ? (33'd0 - dx) : dx;
        ay = dy[32] ? (33'd0 - dy) : dy;
        az = dz[32] ? (33'd0 - dz) : dz;
        q_data.kind = s_kind;
        q_data.dmx  = ax[31:0];
        q_data.dmy  = ay[31:0];
        q_data.dmz  = az[31:0];
        q_data.rest = s_rest_len;
        q_data.k    = s_spring_k;
        q_data.lneg = s_multiplier[31];
        q_data.lmag = s_multiplier[31] ? (32'd0 - s_multiplier) : s_multiplier;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

// ===== rtl/core/sec_queue.sv =====
// short queue between front end and arithmetic back end
module sec_queue #(
    parameter int Depth = sec_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  sec_pkg::spring_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output sec_pkg::spring_t head_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    sec_pkg::spring_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(Depth))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |=> (rd_ptr_reg == $past(rd_ptr_reg)))
        else $error("read pointer moved on empty queue");

endmodule

// ===== rtl/core/sec_back.sv =====
// back end: squares, square root, divide, products and saturation
module sec_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      step_squared,
    input  logic             in_valid,
    output logic             in_ready,
    input  sec_pkg::spring_t in_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [63:0]      m_value,
    output logic             m_saturated
);

    localparam int NL = sec_pkg::DIV_BITS;

    logic adv;

    // stage one: squares and the divisor
    logic        v1_reg;
    logic [63:0] sqx_reg, sqy_reg, sqz_reg, kd_reg, l2_reg;
    logic        kind1_reg, lneg1_reg;
    logic [30:0] rest1_reg;
    logic [31:0] k1_reg, lmag1_reg;

    // loop stages
    logic            lv_reg [NL+1];
    sec_pkg::loop_t  lp_reg [NL+1];

    // tail stages
    logic        v_p1_reg, v_p2_reg, v_p3_reg;
    logic        kind_p1_reg, kind_p2_reg, kind_p3_reg;
    logic        cneg_p1_reg;
    logic [33:0] cmag_p1_reg;
    logic        lneg_p1_reg, kdz_p1_reg, kdz_p2_reg, kdz_p3_reg;
    logic [31:0] lmag_p1_reg, k_p1_reg, k_p2_reg;
    logic        lz_p2_reg, lz_p3_reg;
    logic [94:0] quo_p1_reg, quo_p2_reg, quo_p3_reg;
    logic        pneg_p2_reg, pneg_p3_reg;
    logic [67:0] m_p2_reg, m_p3_reg;
    logic [65:0] pl_p3_reg, ph_p3_reg;

    logic        m_valid_reg;
    logic [63:0] value_reg, value_next;
    logic        sat_reg, sat_next;

    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg   <= in_data.dmx * in_data.dmx;
            sqy_reg   <= in_data.dmy * in_data.dmy;
            sqz_reg   <= in_data.dmz * in_data.dmz;
            kd_reg    <= in_data.k * step_squared;
            l2_reg    <= in_data.lmag * in_data.lmag;
            kind1_reg <= in_data.kind;
            lneg1_reg <= in_data.lneg;
            rest1_reg <= in_data.rest;
            k1_reg    <= in_data.k;
            lmag1_reg <= in_data.lmag;
        end
    end

    // stage two: sum of squares, loop set up
    always_ff @(posedge aclk) begin
        if (adv) begin
            lp_reg[0].kind <= kind1_reg;
            lp_reg[0].rest <= rest1_reg;
            lp_reg[0].k    <= k1_reg;
            lp_reg[0].lneg <= lneg1_reg;
            lp_reg[0].lmag <= lmag1_reg;
            lp_reg[0].kdz  <= (kd_reg == '0);
            lp_reg[0].kd   <= kd_reg;
            lp_reg[0].srem <= {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};
            lp_reg[0].root <= '0;
            lp_reg[0].dnum <= {l2_reg, 31'd0};
            lp_reg[0].drem <= '0;
            lp_reg[0].quo  <= '0;
        end
    end

    // each stage: one quotient bit, and one root bit in the first stages
    for (genvar j = 0; j < NL; j++) begin : g_loop
        localparam int Bit = (j < sec_pkg::SQRT_BITS) ? (sec_pkg::SQRT_BITS - 1 - j) : 0;

        sec_pkg::loop_t nx;
        logic [64:0]    rs;
        logic [64:0]    rd;

        function automatic logic [67:0] trial(input logic [32:0] root);
            trial = ({35'd0, root} << (Bit + 1)) | (68'd1 << (2 * Bit));
        endfunction

        function automatic logic [65:0] sq_rem(input logic [65:0] rem,
                                               input logic [32:0] root);
            logic [67:0] t;
            logic [67:0] r;
            t = trial(root);
            r = {2'b00, rem} - t;
            sq_rem = (t <= {2'b00, rem}) ? r[65:0] : rem;
        endfunction

        function automatic logic [32:0] sq_root(input logic [65:0] rem,
                                                input logic [32:0] root);
            logic [67:0] t;
            t = trial(root);
            sq_root = (t <= {2'b00, rem}) ? (root | (33'd1 << Bit)) : root;
        endfunction

        always_comb begin
            nx = lp_reg[j];
            rs = {lp_reg[j].drem, lp_reg[j].dnum[94]};
            rd = rs - {1'b0, lp_reg[j].kd};
            nx.dnum = {lp_reg[j].dnum[93:0], 1'b0};
            if (rs >= {1'b0, lp_reg[j].kd}) begin
                nx.drem = rd[63:0];
                nx.quo  = {lp_reg[j].quo[93:0], 1'b1};
            end else begin
                nx.drem = rs[63:0];
                nx.quo  = {lp_reg[j].quo[93:0], 1'b0};
            end
            if (j < sec_pkg::SQRT_BITS) begin
                nx.srem = sq_rem(lp_reg[j].srem, lp_reg[j].root);
                nx.root = sq_root(lp_reg[j].srem, lp_reg[j].root);
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                lp_reg[j+1] <= nx;
            end
        end
    end

    // stretch
    logic [34:0] c_w;
    assign c_w = {2'b00, lp_reg[NL].root} - {4'd0, lp_reg[NL].rest};

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_p1_reg <= lp_reg[NL].kind;
            cneg_p1_reg <= c_w[34];
            cmag_p1_reg <= c_w[34] ? (34'd0 - c_w[33:0]) : c_w[33:0];
            lneg_p1_reg <= lp_reg[NL].lneg;
            lmag_p1_reg <= lp_reg[NL].lmag;
            kdz_p1_reg  <= lp_reg[NL].kdz;
            k_p1_reg    <= lp_reg[NL].k;
            quo_p1_reg  <= lp_reg[NL].quo;
        end
    end

    // c squared for energy, c times lambda for the constraint
    logic [33:0] mb_w;
    assign mb_w = (kind_p1_reg == sec_pkg::KIND_CONSTRAINT) ? {2'b00, lmag_p1_reg}
                                                            : cmag_p1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_p2_reg    <= cmag_p1_reg * mb_w;
            kind_p2_reg <= kind_p1_reg;
            pneg_p2_reg <= cneg_p1_reg ^ lneg_p1_reg;
            kdz_p2_reg  <= kdz_p1_reg;
            lz_p2_reg   <= (lmag_p1_reg == '0);
            k_p2_reg    <= k_p1_reg;
            quo_p2_reg  <= quo_p1_reg;
        end
    end

    // energy product in two partials
    always_ff @(posedge aclk) begin
        if (adv) begin
            pl_p3_reg   <= m_p2_reg[33:0] * k_p2_reg;
            ph_p3_reg   <= m_p2_reg[67:34] * k_p2_reg;
            m_p3_reg    <= m_p2_reg;
            kind_p3_reg <= kind_p2_reg;
            pneg_p3_reg <= pneg_p2_reg;
            kdz_p3_reg  <= kdz_p2_reg;
            lz_p3_reg   <= lz_p2_reg;
            quo_p3_reg  <= quo_p2_reg;
        end
    end

    // combine and saturate
    logic [99:0] e_w;
    logic [82:0] s_w;
    logic [96:0] mext_w, t1_w, tot_w;

    always_comb begin
        e_w    = {ph_p3_reg, 34'd0} + {34'd0, pl_p3_reg};
        s_w    = e_w[99:17];
        mext_w = {29'd0, m_p3_reg};
        t1_w   = pneg_p3_reg ? mext_w : (97'd0 - mext_w);
        tot_w  = kdz_p3_reg ? t1_w : (t1_w - {2'b00, quo_p3_reg});
        if (kind_p3_reg == sec_pkg::KIND_ENERGY) begin
            if (s_w[82:63] == '0) begin
                value_next = s_w[63:0];
                sat_next   = 1'b0;
            end else begin
                value_next = 64'h7FFF_FFFF_FFFF_FFFF;
                sat_next   = 1'b1;
            end
        end else if (kdz_p3_reg && !lz_p3_reg) begin
            value_next = 64'h8000_0000_0000_0000;
            sat_next   = 1'b1;
        end else if ((&tot_w[96:63]) || !(|tot_w[96:63])) begin
            value_next = tot_w[63:0];
            sat_next   = 1'b0;
        end else begin
            value_next = tot_w[96] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    // valid flags move with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v_p1_reg    <= 1'b0;
            v_p2_reg    <= 1'b0;
            v_p3_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i <= NL; i++) begin
                lv_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg    <= in_valid;
            lv_reg[0] <= v1_reg;
            for (int i = 0; i < NL; i++) begin
                lv_reg[i+1] <= lv_reg[i];
            end
            v_p1_reg    <= lv_reg[NL];
            v_p2_reg    <= v_p1_reg;
            v_p3_reg    <= v_p2_reg;
            m_valid_reg <= v_p3_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = value_reg;
    assign m_saturated = sat_reg;

endmodule
